>>> rtl/fsla_pkg.sv
`default_nettype none

package fsla_pkg;

  // Number of flow controllers watched; mask width is fixed by the result field
  localparam int MAX_CONTROLLERS = 16;
  localparam int MASK_W          = 16;
  // Readings with an index at or above this are ignored
  localparam int CTRL_LIMIT      = (MAX_CONTROLLERS < MASK_W) ? MAX_CONTROLLERS : MASK_W;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] PANIC_COUNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PANIC_SECONDS     = 3'd0,
    REG_BEEP_QUOTA        = 3'd1,
    REG_BEEP_ENABLE       = 3'd2,
    REG_STOP_ENABLE       = 3'd3,
    REG_COMMAND_ZERO_BAND = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] BAND_RESET = 15'd10;

  typedef struct packed {
    logic [3:0]         controller_index;
    logic signed [15:0] commanded_flow;
    logic signed [15:0] measured_flow;
    logic [15:0]        error_magnitude;
    logic               last_of_poll;
  } in_t;

  typedef struct packed {
    logic [15:0] offender_mask;
    logic        panic_active;
    logic        first_detect;
    logic        alarm_request;
    logic        stop_request;
  } out_t;

  typedef struct packed {
    logic [15:0] panic_seconds;
    logic [15:0] beep_quota;
    logic        beep_enable;
    logic        stop_enable;
    logic [14:0] command_zero_band;
  } cfg_t;

  // Screened reading handed from the input stage to the poll logic
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [MASK_W-1:0] hit;
  } screen_t;

  // Magnitude of a 16-bit two's complement value; -32768 gives 32768
  function automatic logic [16:0] magnitude16(input logic signed [15:0] v);
    logic [16:0] mag;
    if (v[15]) begin
      mag = {1'b0, ~v} + 17'd1;
    end else begin
      mag = {1'b0, v};
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fsla_cfg.sv
`default_nettype none

module fsla_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output fsla_pkg::cfg_t     cfg
);
  import fsla_pkg::*;

  cfg_t regs;

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.panic_seconds     <= 16'd1;
      regs.beep_quota        <= 16'd1;
      regs.beep_enable       <= 1'b0;
      regs.stop_enable       <= 1'b0;
      regs.command_zero_band <= BAND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PANIC_SECONDS:     regs.panic_seconds     <= cfg_data;
        REG_BEEP_QUOTA:        regs.beep_quota        <= cfg_data;
        REG_BEEP_ENABLE:       regs.beep_enable       <= cfg_data[0];
        REG_STOP_ENABLE:       regs.stop_enable       <= cfg_data[0];
        REG_COMMAND_ZERO_BAND: regs.command_zero_band <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

>>> rtl/fsla_screen.sv
`default_nettype none

module fsla_screen (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fsla_pkg::in_t in_data,
  input  wire logic [14:0]   command_zero_band,
  input  wire logic          advance,
  output fsla_pkg::screen_t  scr
);
  import fsla_pkg::*;

  logic        s_valid;
  in_t         s_data;
  logic [16:0] cmd_mag;
  logic [16:0] meas_mag;
  logic        offend;

  // Input register; holds while the poll stage cannot take its request
  assign in_stall = s_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s_data <= in_data;
    end
  end

  // Offender test: commanded above the band, measured within half the error
  always_comb begin
    cmd_mag  = magnitude16(s_data.commanded_flow);
    meas_mag = magnitude16(s_data.measured_flow);
    offend   = ({1'b0, s_data.controller_index} < 5'(CTRL_LIMIT))
               && (cmd_mag > {2'b00, command_zero_band})
               && ({meas_mag, 1'b0} <= {2'b00, s_data.error_magnitude});
  end

  always_comb begin
    scr.valid = s_valid;
    scr.last  = s_data.last_of_poll;
    scr.hit   = offend ? (MASK_W'(1) << s_data.controller_index) : '0;
  end

endmodule

`default_nettype wire

>>> rtl/fsla_poll.sv
`default_nettype none

module fsla_poll (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fsla_pkg::screen_t scr,
  input  wire fsla_pkg::cfg_t    cfg,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fsla_pkg::out_t         out_data
);
  import fsla_pkg::*;

  logic [MASK_W-1:0] poll_offenders;
  logic [CNT_W-1:0]  panic_count;
  logic              panicking;
  logic [15:0]       sweep_count;

  logic [MASK_W-1:0] mask_next;
  logic [CNT_W-1:0]  panic_count_next;
  logic              panicking_next;
  logic [15:0]       sweep_count_next;
  logic              have_panic;
  logic              held;
  logic              over;
  logic              first;
  logic              alarm;
  logic              stop;
  logic              fire;

  // A reading that yields no result always moves; a last one needs a free slot
  assign advance = !scr.last || !out_valid || !out_stall;
  assign fire    = scr.valid && advance;

  // End-of-poll decision
  always_comb begin
    mask_next  = poll_offenders | scr.hit;
    have_panic = (mask_next != '0);
    if (have_panic) begin
      held = panicking;
      if (!panicking && (panic_count != PANIC_COUNT_MAX)) begin
        panic_count_next = panic_count + 1'b1;
      end else begin
        panic_count_next = panic_count;
      end
    end else begin
      held             = 1'b0;
      panic_count_next = '0;
    end
    over           = panic_count_next > {1'b0, cfg.panic_seconds};
    first          = over && !held && have_panic;
    panicking_next = held || first;
    alarm          = over && cfg.beep_enable && (sweep_count < cfg.beep_quota);
    stop           = over && !alarm && cfg.stop_enable
                     && (!cfg.beep_enable || (sweep_count >= cfg.beep_quota));
    if (alarm) begin
      sweep_count_next = sweep_count + 16'd1;
    end else if (stop) begin
      sweep_count_next = '0;
    end else begin
      sweep_count_next = sweep_count;
    end
  end

  // Poll state
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_offenders <= '0;
      panic_count    <= '0;
      panicking      <= 1'b0;
      sweep_count    <= '0;
    end else if (fire) begin
      if (scr.last) begin
        poll_offenders <= '0;
        panic_count    <= panic_count_next;
        panicking      <= panicking_next;
        sweep_count    <= sweep_count_next;
      end else begin
        poll_offenders <= mask_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && scr.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && scr.last) begin
      out_data.offender_mask <= mask_next;
      out_data.panic_active  <= panicking_next;
      out_data.first_detect  <= first;
      out_data.alarm_request <= alarm;
      out_data.stop_request  <= stop;
    end
  end

  // Checks
  a_first_implies_panic: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.first_detect |-> out_data.panic_active)
    else $error("first_detect without panic_active");

  a_alarm_stop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.alarm_request && out_data.stop_request))
    else $error("alarm and stop requested together");

  a_panic_has_count: assert property (@(posedge clk) disable iff (rst)
    panicking |-> (panic_count != '0))
    else $error("panicking with zero panic count");

  a_stop_clears_alarms: assert property (@(posedge clk) disable iff (rst)
    fire && scr.last && stop |=> (sweep_count == '0))
    else $error("alarm count not cleared by stop");

  a_poll_mask_clears: assert property (@(posedge clk) disable iff (rst)
    fire && scr.last |=> (poll_offenders == '0))
    else $error("offender mask not cleared at end of poll");

endmodule

`default_nettype wire

>>> rtl/flow_supply_loss_alarm_top.sv
// Flow supply loss alarm.
// Input channel (in_valid / in_stall / in_data): one request per controller
// reading; last_of_poll marks the final reading of a one-second poll. A
// reading is taken every cycle while in_stall is low.
// Output channel (out_valid / out_stall / out_data): one request per poll,
// carrying the offender mask, panic flag, first detection and the alarm
// sweep / stop requests for that poll.
// A last reading passes the input register and then the result register.
// Throughput: one reading per cycle while in_stall is low, set by the
// single input register and the single result register; the poll
// decision is one pass of logic.
// Config (cfg_write / cfg_index / cfg_data) is for the user to write only
// while idle, unenforced by the block; writes past the list are ignored.
// Reset (rst, synchronous) restores register defaults and clears the poll
// mask, panic count, panicking flag and alarm count; no clearing pass.
// When out_stall holds a result, readings that end no poll keep flowing;
// the next last reading waits in the input register and in_stall rises.
`default_nettype none

module flow_supply_loss_alarm_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fsla_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output fsla_pkg::out_t      out_data,
  input  wire logic           cfg_write,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import fsla_pkg::*;

  cfg_t    cfg;
  screen_t scr;
  logic    advance;

  fsla_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsla_screen u_screen (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .command_zero_band (cfg.command_zero_band),
    .advance           (advance),
    .scr               (scr)
  );

  fsla_poll u_poll (
    .clk       (clk),
    .rst       (rst),
    .scr       (scr),
    .cfg       (cfg),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
